// ===== hw/rtl/fdc_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the frame deframer.
package fdc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam logic [7:0]  START_BYTE_RESET = 8'hAA;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_tag;
    logic [7:0]  payload_length;
    logic        crc_good;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
  } fdc_result_t;

  // Shift one byte through the CRC, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fdc_if.sv =====
// Handshake interfaces for the byte input, result output and configuration channels.
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  frame_seq;
  logic [7:0]  frame_tag;
  logic [7:0]  payload_length;
  logic        crc_good;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;
  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, output frame_seq, output frame_tag,
                  output payload_length, output crc_good, output received_crc,
                  output computed_crc, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_index, input frame_seq, input frame_tag,
                  input payload_length, input crc_good, input received_crc,
                  input computed_crc, output ready);
endinterface

interface fdc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_byte;
  modport source (output valid, output start_byte, input ready);
  modport sink   (input valid, input start_byte, output ready);
endinterface

// ===== hw/rtl/frame_deframer_crc16_check.sv =====
// Top level of the start-byte / length deframer with CRC-16 check.
// Takes one received byte per clock while ready is high and emits one result
// per payload byte plus a frame-end result carrying the CRC verdict; header
// and first CRC bytes and bytes seen while hunting give no result. Sustained
// rate is one byte per cycle when not stalled; a byte's result is loaded
// into the result register after the byte is accepted (input register, then
// the parse step with its eight-bit CRC update into the result register).
// Ready drops only while the result register is full and not taken. The
// start byte register may be written only while no byte is in flight.
module frame_deframer_crc16_check (
  input logic       clk,
  input logic       rst_n,
  fdc_in_if.sink    in_chan,
  fdc_out_if.source out_chan,
  fdc_cfg_if.sink   cfg_chan
);
  import fdc_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic [7:0]  start_byte_r;
  logic        out_vld_r;
  fdc_result_t out_res_r;
  logic        res_valid;
  fdc_result_t res;
  logic        out_load_ok;
  logic        step_en;

  assign out_load_ok = !out_vld_r || out_chan.ready;
  // Advance the held byte unless it makes a result with nowhere to go.
  assign step_en     = in_vld_r && (!res_valid || out_load_ok);
  assign in_chan.ready  = !in_vld_r || step_en;
  assign cfg_chan.ready = 1'b1;

  fdc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .byte_in    (in_byte_r),
    .start_byte (start_byte_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      start_byte_r <= START_BYTE_RESET;
    end else begin
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (out_load_ok) begin
        out_vld_r <= step_en && res_valid;
      end
      if (cfg_chan.valid) begin
        start_byte_r <= cfg_chan.start_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.in_byte;
    end
    if (out_load_ok && step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.result_kind    = out_res_r.result_kind;
  assign out_chan.payload_byte   = out_res_r.payload_byte;
  assign out_chan.payload_index  = out_res_r.payload_index;
  assign out_chan.frame_seq      = out_res_r.frame_seq;
  assign out_chan.frame_tag      = out_res_r.frame_tag;
  assign out_chan.payload_length = out_res_r.payload_length;
  assign out_chan.crc_good       = out_res_r.crc_good;
  assign out_chan.received_crc   = out_res_r.received_crc;
  assign out_chan.computed_crc   = out_res_r.computed_crc;

endmodule

// ===== hw/rtl/fdc_parser.sv =====
// Frame parse state, running CRC and per-byte result generation.
module fdc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          byte_in,
  input  logic [7:0]          start_byte,
  output logic                res_valid,
  output fdc_pkg::fdc_result_t res
);
  import fdc_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CRC  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        crc_cnt_r, crc_cnt_nxt;
  logic [15:0] crc_upd;
  logic [15:0] rcv_crc;
  logic [7:0]  pay_cnt_inc;

  // Restart from zero on the start byte.
  assign crc_upd     = crc16_byte((phase_r == PH_HUNT) ? 16'h0000 : crc_r, byte_in);
  assign rcv_crc     = {byte_in, crc_lo_r};
  assign pay_cnt_inc = pay_cnt_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    seq_nxt     = seq_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    pay_cnt_nxt = pay_cnt_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    crc_cnt_nxt = crc_cnt_r;
    res_valid   = 1'b0;
    res                = '0;
    res.frame_seq      = seq_r;
    res.frame_tag      = id_r;
    res.payload_length = len_r;
    case (phase_r)
      PH_HUNT: begin
        if (byte_in == start_byte) begin
          crc_nxt     = crc_upd;
          hdr_cnt_nxt = 3'd1;
          phase_nxt   = PH_HEAD;
        end
      end
      PH_HEAD: begin
        crc_nxt = crc_upd;
        if (hdr_cnt_r <= 3'd1) begin
          seq_nxt     = byte_in;
          hdr_cnt_nxt = 3'd2;
        end else if (hdr_cnt_r == 3'd2) begin
          id_nxt      = byte_in;
          hdr_cnt_nxt = 3'd3;
        end else begin
          len_nxt     = byte_in;
          hdr_cnt_nxt = 3'd4;
          if (byte_in == 8'd0) begin
            crc_cnt_nxt = 1'b0;
            phase_nxt   = PH_CRC;
          end else begin
            pay_cnt_nxt = 8'd0;
            phase_nxt   = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_nxt           = crc_upd;
        res_valid         = 1'b1;
        res.result_kind   = KIND_PAYLOAD;
        res.payload_byte  = byte_in;
        res.payload_index = pay_cnt_r;
        pay_cnt_nxt       = pay_cnt_inc;
        if (pay_cnt_inc == len_r) begin
          crc_cnt_nxt = 1'b0;
          phase_nxt   = PH_CRC;
        end
      end
      PH_CRC: begin
        if (!crc_cnt_r) begin
          crc_lo_nxt  = byte_in;
          crc_cnt_nxt = 1'b1;
        end else begin
          res_valid        = 1'b1;
          res.result_kind  = KIND_FRAME_END;
          res.crc_good     = (rcv_crc == crc_r);
          res.received_crc = rcv_crc;
          res.computed_crc = crc_r;
          crc_cnt_nxt      = 1'b0;
          phase_nxt        = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hdr_cnt_r <= 3'd0;
      seq_r     <= 8'd0;
      id_r      <= 8'd0;
      len_r     <= 8'd0;
      pay_cnt_r <= 8'd0;
      crc_r     <= 16'h0000;
      crc_lo_r  <= 8'd0;
      crc_cnt_r <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      seq_r     <= seq_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
      crc_cnt_r <= crc_cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/fdc_checker.sv =====
// Port-level assertions for the deframer, bound to the top level.
module fdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        result_kind,
  input logic [7:0]  payload_byte,
  input logic [7:0]  payload_index,
  input logic [7:0]  payload_length,
  input logic        crc_good,
  input logic [15:0] received_crc,
  input logic [15:0] computed_crc
);
  import fdc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_end_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && result_kind == KIND_FRAME_END) |->
      (payload_byte == 8'd0 && payload_index == 8'd0))
    else $error("frame end carries payload fields");

  a_end_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && result_kind == KIND_FRAME_END) |->
      (crc_good == (received_crc == computed_crc)))
    else $error("CRC verdict disagrees with CRC values");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && result_kind == KIND_PAYLOAD) |->
      (!crc_good && received_crc == 16'h0000 && computed_crc == 16'h0000 &&
       payload_index < payload_length))
    else $error("payload item has bad index or CRC fields");

endmodule

bind frame_deframer_crc16_check fdc_checker u_fdc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .result_kind    (out_chan.result_kind),
  .payload_byte   (out_chan.payload_byte),
  .payload_index  (out_chan.payload_index),
  .payload_length (out_chan.payload_length),
  .crc_good       (out_chan.crc_good),
  .received_crc   (out_chan.received_crc),
  .computed_crc   (out_chan.computed_crc)
);

// ===== tb/tb_frame_deframer_crc16_check.sv =====
// Testbench for the CRC-16 frame deframer: directed table, then random frames checked by a predictor.
`timescale 1ns / 1ps

module tb_frame_deframer_crc16_check;
  import fdc_pkg::*;

  typedef enum logic [1:0] {HUNT = 2'd0, HEADER = 2'd1, PAYLOAD = 2'd2, CRC_WAIT = 2'd3} phase_t;
  typedef enum logic [1:0] {ROW_LITERAL, ROW_CRC_LOW, ROW_CRC_HIGH} row_src_t;

  typedef struct {
    row_src_t    src;
    logic [7:0]  value;
    bit          has_exp;
    fdc_result_t exp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fdc_in_if  in_if ();
  fdc_out_if out_if ();
  fdc_cfg_if cfg_if ();

  frame_deframer_crc16_check DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // Deframer shadow state
  logic [7:0]  p_start   = START_BYTE_RESET;
  phase_t      p_phase   = HUNT;
  logic [2:0]  p_hdr     = 3'd0;
  logic [7:0]  p_seq     = 8'h00;
  logic [7:0]  p_id      = 8'h00;
  logic [7:0]  p_len     = 8'h00;
  logic [7:0]  p_cnt     = 8'h00;
  logic [15:0] p_crc     = 16'h0000;
  logic [7:0]  p_crc_lo  = 8'h00;
  logic        p_crc_cnt = 1'b0;

  fdc_result_t deframed_queue [$];
  fdc_result_t want;
  int          mismatches = 0;

  // Typed expectation for the byte on offer, set by the table walk
  bit          row_has_exp = 1'b0;
  fdc_result_t row_exp;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_go   = 1'b0;
  bit          hold_done = 1'b0;
  logic [7:0]  cfg_start = START_BYTE_RESET;
  int          frame_items;

  dir_row_t    dir_rows [25];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic fdc_result_t payload_exp(input logic [7:0] b, input logic [7:0] idx,
                                              input logic [7:0] seq, input logic [7:0] id,
                                              input logic [7:0] len);
    fdc_result_t r;
    r = '0;
    r.result_kind    = KIND_PAYLOAD;
    r.payload_byte   = b;
    r.payload_index  = idx;
    r.frame_seq      = seq;
    r.frame_tag      = id;
    r.payload_length = len;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    fdc_result_t r;
    logic        emit;
    logic [15:0] rcv;
    r = '0;
    emit = 1'b0;
    case (p_phase)
      HUNT: begin
        if (b == p_start) begin
          p_crc   = crc_next(16'h0000, b);
          p_hdr   = 3'd1;
          p_phase = HEADER;
        end
      end
      HEADER: begin
        p_crc = crc_next(p_crc, b);
        if (p_hdr <= 3'd1) begin
          p_seq = b;
          p_hdr = 3'd2;
        end else if (p_hdr == 3'd2) begin
          p_id  = b;
          p_hdr = 3'd3;
        end else begin
          p_len = b;
          p_hdr = 3'd4;
          if (b == 8'h00) begin
            p_crc_cnt = 1'b0;
            p_phase   = CRC_WAIT;
          end else begin
            p_cnt   = 8'h00;
            p_phase = PAYLOAD;
          end
        end
      end
      PAYLOAD: begin
        p_crc = crc_next(p_crc, b);
        r     = payload_exp(b, p_cnt, p_seq, p_id, p_len);
        emit  = 1'b1;
        p_cnt = p_cnt + 8'd1;
        if (p_cnt == p_len) begin
          p_crc_cnt = 1'b0;
          p_phase   = CRC_WAIT;
        end
      end
      CRC_WAIT: begin
        if (!p_crc_cnt) begin
          p_crc_lo  = b;
          p_crc_cnt = 1'b1;
        end else begin
          rcv              = {b, p_crc_lo};
          r.result_kind    = KIND_FRAME_END;
          r.frame_seq      = p_seq;
          r.frame_tag      = p_id;
          r.payload_length = p_len;
          r.crc_good       = (rcv == p_crc);
          r.received_crc   = rcv;
          r.computed_crc   = p_crc;
          emit             = 1'b1;
          p_crc_cnt        = 1'b0;
          p_phase          = HUNT;
        end
      end
    endcase
    if (row_has_exp) begin
      deframed_queue.push_back(row_exp);
    end else if (emit) begin
      deframed_queue.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t %s: expected %h actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // Score results, then advance the shadow state on accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (deframed_queue.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none actual kind %h byte %h", $time,
                   out_if.result_kind, out_if.payload_byte);
        end else begin
          want = deframed_queue.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(out_if.result_kind));
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_if.payload_byte));
          check_field("payload_index", 16'(want.payload_index),
                      16'(out_if.payload_index));
          check_field("frame_seq", 16'(want.frame_seq), 16'(out_if.frame_seq));
          check_field("frame_tag", 16'(want.frame_tag), 16'(out_if.frame_tag));
          check_field("payload_length", 16'(want.payload_length),
                      16'(out_if.payload_length));
          check_field("crc_good", 16'(want.crc_good), 16'(out_if.crc_good));
          check_field("received_crc", want.received_crc, out_if.received_crc);
          check_field("computed_crc", want.computed_crc, out_if.computed_crc);
        end
      end
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.in_byte);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        p_start = cfg_if.start_byte;
      end
    end
  end

  // Result sink: random stalls, one long hold-off when requested
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (299) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (deframed_queue.size() != 0) @(negedge clk);
    // let bytes that give no result clear the pipeline
    repeat (8) @(negedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    in_if.valid <= 1'b0;
    @(negedge clk);
    drain_results();
    cfg_if.valid      <= 1'b1;
    cfg_if.start_byte <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cfg_start = v;
  endtask

  // keep > 0 truncates the frame to that many bytes
  task automatic send_frame(input int len, input bit corrupt, input int keep);
    logic [7:0]  fb [$];
    logic [15:0] c;
    logic [7:0]  v;
    fb.push_back(cfg_start);
    c = crc_next(16'h0000, cfg_start);
    for (int k = 0; k < 2; k++) begin
      v = 8'($urandom);
      fb.push_back(v);
      c = crc_next(c, v);
    end
    fb.push_back(len[7:0]);
    c = crc_next(c, len[7:0]);
    for (int k = 0; k < len; k++) begin
      v = 8'($urandom);
      fb.push_back(v);
      c = crc_next(c, v);
    end
    if (corrupt) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    while (keep > 0 && fb.size() > keep) void'(fb.pop_back());
    foreach (fb[k]) begin
      send_byte(fb[k]);
      frame_items++;
    end
  endtask

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [7:0] b;
    logic [7:0] start_pick;
    int         pick;
    int         len_pick;
    int         len;

    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.in_byte     <= 8'h00;
    cfg_if.valid      <= 1'b0;
    cfg_if.start_byte <= 8'h00;

    dir_rows = '{
      '{ROW_LITERAL,  8'h00, 1'b0, '0},   // ignored while hunting
      '{ROW_LITERAL,  8'hFF, 1'b0, '0},
      '{ROW_LITERAL,  8'h55, 1'b0, '0},
      '{ROW_LITERAL,  8'hAA, 1'b0, '0},
      '{ROW_LITERAL,  8'h01, 1'b0, '0},
      '{ROW_LITERAL,  8'h02, 1'b0, '0},
      '{ROW_LITERAL,  8'h03, 1'b0, '0},
      '{ROW_LITERAL,  8'h00, 1'b1, payload_exp(8'h00, 8'd0, 8'h01, 8'h02, 8'h03)},
      '{ROW_LITERAL,  8'hFF, 1'b1, payload_exp(8'hFF, 8'd1, 8'h01, 8'h02, 8'h03)},
      // start marker inside a frame is plain payload
      '{ROW_LITERAL,  8'hAA, 1'b1, payload_exp(8'hAA, 8'd2, 8'h01, 8'h02, 8'h03)},
      '{ROW_CRC_LOW,  8'h00, 1'b0, '0},
      '{ROW_CRC_HIGH, 8'h00, 1'b0, '0},
      // zero-length frame goes straight to the CRC
      '{ROW_LITERAL,  8'hAA, 1'b0, '0},
      '{ROW_LITERAL,  8'hFF, 1'b0, '0},
      '{ROW_LITERAL,  8'h00, 1'b0, '0},
      '{ROW_LITERAL,  8'h00, 1'b0, '0},
      '{ROW_CRC_LOW,  8'h00, 1'b0, '0},
      '{ROW_CRC_HIGH, 8'h00, 1'b0, '0},
      // one-byte frame with a wrong CRC
      '{ROW_LITERAL,  8'hAA, 1'b0, '0},
      '{ROW_LITERAL,  8'hFF, 1'b0, '0},
      '{ROW_LITERAL,  8'hFF, 1'b0, '0},
      '{ROW_LITERAL,  8'h01, 1'b0, '0},
      '{ROW_LITERAL,  8'h80, 1'b1, payload_exp(8'h80, 8'd0, 8'hFF, 8'hFF, 8'h01)},
      '{ROW_LITERAL,  8'h00, 1'b0, '0},
      '{ROW_LITERAL,  8'h00, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 71;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].src)
        ROW_CRC_LOW:  b = p_crc[7:0];
        ROW_CRC_HIGH: b = p_crc[15:8];
        default:      b = dir_rows[i].value;
      endcase
      row_exp     = dir_rows[i].exp;
      row_has_exp = dir_rows[i].has_exp;
      send_byte(b);
    end
    row_has_exp = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0:       start_pick = 8'h00;
        1:       start_pick = 8'hFF;
        3:       start_pick = 8'h7E;
        5:       start_pick = START_BYTE_RESET;
        default: start_pick = 8'($urandom);
      endcase
      write_start(start_pick);
      frame_items = 0;
      if (ph == 5) begin
        // hold off the sink while a maximum-length frame backs up the input
        hold_go = 1'b1;
        send_frame(255, 1'b0, 0);
      end
      while (frame_items < 170) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
          len_pick = $urandom_range(0, 99);
          if (len_pick < 2) begin
            len = 254 + $urandom_range(0, 1);
          end else if (len_pick < 12) begin
            len = $urandom_range(13, 64);
          end else begin
            len = $urandom_range(0, 12);
          end
          send_frame(len, $urandom_range(0, 99) < 20,
                     (pick < 15) ? $urandom_range(1, len + 5) : 0);
        end
      end
    end

    in_if.valid <= 1'b0;
    @(negedge clk);
    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && deframed_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
